// ===== rtl/som_bmu_pkg.sv =====
// som_bmu_pkg: shared constants and controller/datapath interface types
// for the som best matching unit search; no dependencies

package som_bmu_pkg;

    // default map geometry and sample format
    localparam int MAP_SIZE_DEF    = 16;
    localparam int COMPONENTS_DEF  = 8;
    localparam int VALUE_WIDTH_DEF = 16;

    // fixed field widths
    localparam int ROW_W    = 4;
    localparam int COMP_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int DIST_W   = 19;
    localparam int VLEN_W   = 4;

    localparam logic [DIST_W-1:0] DIST_MAX   = '1;
    localparam logic [VLEN_W-1:0] VLEN_RESET = VLEN_W'(8);

    // request command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic wr_proto;
        logic wr_query;
        logic scan_start;
        logic scan_step;
        logic out_load;
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic addr_last;
        logic pipe_idle;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/som_bmu_ctrl.sv =====
// som_bmu_ctrl: request decode and scan sequencing state machine
// depends on som_bmu_pkg for command and status types

module som_bmu_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_cmd,
    input  logic                   i_last,
    input  som_bmu_pkg::t_dp_status i_status,
    output logic                   o_in_stall,
    output som_bmu_pkg::t_ctrl_cmd o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == som_bmu_pkg::CMD_LOAD) begin
                        o_ctrl.wr_proto = 1'b1;
                    end else begin
                        o_ctrl.wr_query = 1'b1;
                        if (i_last) begin
                            o_ctrl.scan_start = 1'b1;
                            n_state           = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if (i_status.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_status.pipe_idle) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold the winner until the output register can take it
                if (i_status.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/som_bmu_dp.sv =====
// som_bmu_dp: prototype memory, query buffer, l1 distance adder tree,
// winner tracking and output register; depends on som_bmu_pkg

module som_bmu_dp #(
    parameter int MAP_SIZE    = som_bmu_pkg::MAP_SIZE_DEF,
    parameter int COMPONENTS  = som_bmu_pkg::COMPONENTS_DEF,
    parameter int VALUE_WIDTH = som_bmu_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  som_bmu_pkg::t_ctrl_cmd              i_ctrl,
    output som_bmu_pkg::t_dp_status             o_status,
    input  logic [som_bmu_pkg::ROW_W-1:0]       i_row,
    input  logic [som_bmu_pkg::ROW_W-1:0]       i_col,
    input  logic [som_bmu_pkg::COMP_W-1:0]      i_component,
    input  logic signed [som_bmu_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                                i_cfg_we,
    input  logic [som_bmu_pkg::VLEN_W-1:0]      i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [som_bmu_pkg::ROW_W-1:0]       o_winner_row,
    output logic [som_bmu_pkg::ROW_W-1:0]       o_winner_col,
    output logic [som_bmu_pkg::DIST_W-1:0]      o_min_distance
);

    localparam int NEURONS = MAP_SIZE * MAP_SIZE;
    localparam int NA      = $clog2(NEURONS);
    localparam int RW      = $clog2(MAP_SIZE);
    localparam int LEVELS  = $clog2(COMPONENTS);
    localparam int PAD     = 1 << LEVELS;
    localparam int CW      = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
    localparam int AW      = VALUE_WIDTH + LEVELS;
    localparam int DW      = som_bmu_pkg::DIST_W;

    // one memory word per neuron, one lane per component
    logic [COMPONENTS-1:0][VALUE_WIDTH-1:0] r_proto [NEURONS];
    logic [VALUE_WIDTH-1:0]                 r_query [COMPONENTS];
    logic [COMPONENTS-1:0][VALUE_WIDTH-1:0] r_rd_data;

    logic [som_bmu_pkg::VLEN_W-1:0] r_vlen;

    logic                        wr_ok;
    logic                        lane_ok;
    logic [NA-1:0]               wr_addr;
    logic [CW-1:0]               wr_lane;
    logic signed [VALUE_WIDTH-1:0] sample_v;

    logic [NA-1:0] r_addr;
    logic [RW-1:0] r_scan_row;
    logic [RW-1:0] r_scan_col;

    logic          r_a_valid;
    logic          r_a_first;
    logic [RW-1:0] r_a_row;
    logic [RW-1:0] r_a_col;

    logic [AW-1:0] r_tree [LEVELS+1][PAD];
    logic [LEVELS:0] r_pv;
    logic [LEVELS:0] r_pfirst;
    logic [RW-1:0] r_prow [LEVELS+1];
    logic [RW-1:0] r_pcol [LEVELS+1];

    logic [DW-1:0] sum_dist;
    logic [DW-1:0] r_best_dist;
    logic [RW-1:0] r_best_row;
    logic [RW-1:0] r_best_col;
    logic          r_out_valid;
    logic [som_bmu_pkg::ROW_W-1:0] r_out_row;
    logic [som_bmu_pkg::ROW_W-1:0] r_out_col;
    logic [DW-1:0] r_out_dist;

    // request decode
    assign lane_ok  = 32'(i_component) < COMPONENTS;
    assign wr_ok    = (32'(i_row) < MAP_SIZE) && (32'(i_col) < MAP_SIZE) && lane_ok;
    assign wr_addr  = NA'(32'(i_row) * MAP_SIZE + 32'(i_col));
    assign wr_lane  = CW'(i_component);
    // wraps or sign-extends the sample to the stored width
    assign sample_v = VALUE_WIDTH'(i_sample_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= som_bmu_pkg::VLEN_RESET;
        end else if (i_cfg_we) begin
            r_vlen <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_proto && wr_ok) begin
            r_proto[wr_addr][wr_lane] <= sample_v;
        end
        if (i_ctrl.scan_step) begin
            r_rd_data <= r_proto[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_query && lane_ok) begin
            r_query[wr_lane] <= sample_v;
        end
    end

    // row-major scan address generation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_scan_row <= '0;
            r_scan_col <= '0;
        end else if (i_ctrl.scan_start) begin
            r_addr     <= '0;
            r_scan_row <= '0;
            r_scan_col <= '0;
        end else if (i_ctrl.scan_step) begin
            r_addr <= r_addr + NA'(1);
            if (r_scan_col == RW'(MAP_SIZE - 1)) begin
                r_scan_col <= '0;
                r_scan_row <= r_scan_row + RW'(1);
            end else begin
                r_scan_col <= r_scan_col + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_ctrl.scan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_first <= (r_addr == '0);
        r_a_row   <= r_scan_row;
        r_a_col   <= r_scan_col;
    end

    // leaves: masked absolute differences, one lane per component
    for (genvar k = 0; k < PAD; k++) begin : g_leaf
        if (k < COMPONENTS) begin : g_act
            logic signed [VALUE_WIDTH:0] diff;
            logic [VALUE_WIDTH:0]        mag;
            assign diff = (VALUE_WIDTH+1)'(signed'(r_query[k]))
                        - (VALUE_WIDTH+1)'(signed'(r_rd_data[k]));
            assign mag  = diff[VALUE_WIDTH] ? (VALUE_WIDTH+1)'(-diff) : diff;
            always_ff @(posedge i_clk) begin
                r_tree[0][k] <= (k < 32'(r_vlen)) ? AW'(mag[VALUE_WIDTH-1:0]) : '0;
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_tree[0][k] <= '0;
            end
        end
    end

    // registered adder tree, each level held in its own register
    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        for (genvar i = 0; i < PAD; i++) begin : g_node
            if (i < (PAD >> l)) begin : g_add
                always_ff @(posedge i_clk) begin
                    r_tree[l][i] <= r_tree[l-1][2*i] + r_tree[l-1][2*i+1];
                end
            end else begin : g_idle
                always_ff @(posedge i_clk) begin
                    r_tree[l][i] <= '0;
                end
            end
        end
    end

    // neuron tag travels alongside the tree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv[0] <= r_a_valid;
            for (int l = 1; l <= LEVELS; l++) begin
                r_pv[l] <= r_pv[l-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfirst[0] <= r_a_first;
        r_prow[0]   <= r_a_row;
        r_pcol[0]   <= r_a_col;
        for (int l = 1; l <= LEVELS; l++) begin
            r_pfirst[l] <= r_pfirst[l-1];
            r_prow[l]   <= r_prow[l-1];
            r_pcol[l]   <= r_pcol[l-1];
        end
    end

    // saturate the total to the distance width
    always_comb begin
        if (64'(r_tree[LEVELS][0]) > 64'(som_bmu_pkg::DIST_MAX)) begin
            sum_dist = som_bmu_pkg::DIST_MAX;
        end else begin
            sum_dist = DW'(r_tree[LEVELS][0]);
        end
    end

    // strict less-than keeps the earliest neuron on a tie
    always_ff @(posedge i_clk) begin
        if (r_pv[LEVELS] && (r_pfirst[LEVELS] || (sum_dist < r_best_dist))) begin
            r_best_dist <= sum_dist;
            r_best_row  <= r_prow[LEVELS];
            r_best_col  <= r_pcol[LEVELS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_row  <= som_bmu_pkg::ROW_W'(r_best_row);
            r_out_col  <= som_bmu_pkg::ROW_W'(r_best_col);
            r_out_dist <= r_best_dist;
        end
    end

    assign o_status.addr_last = (r_addr == NA'(NEURONS - 1));
    assign o_status.pipe_idle = !r_a_valid && !(|r_pv);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_winner_row   = r_out_row;
    assign o_winner_col   = r_out_col;
    assign o_min_distance = r_out_dist;

endmodule

// ===== rtl/som_best_matching_unit_l1.sv =====
// loads and non-final query requests are accepted back to back
// a final query request runs a scan of MAP_SIZE*MAP_SIZE neurons, one neuron per cycle
// through the single read port of the prototype memory; the result passes through the
// adder tree and winner compare to the output register, input stalled until it is loaded
// synchronous active-low reset clears control and sets vector_length to 8;
// prototype and query storage are not cleared and need no clearing pass

module som_best_matching_unit_l1 #(
    parameter int MAP_SIZE    = som_bmu_pkg::MAP_SIZE_DEF,
    parameter int COMPONENTS  = som_bmu_pkg::COMPONENTS_DEF,
    parameter int VALUE_WIDTH = som_bmu_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_cmd,
    input  logic [som_bmu_pkg::ROW_W-1:0]           i_row,
    input  logic [som_bmu_pkg::ROW_W-1:0]           i_col,
    input  logic [som_bmu_pkg::COMP_W-1:0]          i_component,
    input  logic signed [som_bmu_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic                                    i_last,
    input  logic                                    i_cfg_we,
    input  logic [som_bmu_pkg::VLEN_W-1:0]          i_cfg_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [som_bmu_pkg::ROW_W-1:0]           o_winner_row,
    output logic [som_bmu_pkg::ROW_W-1:0]           o_winner_col,
    output logic [som_bmu_pkg::DIST_W-1:0]          o_min_distance
);

    som_bmu_pkg::t_ctrl_cmd  ctrl;
    som_bmu_pkg::t_dp_status status;

    som_bmu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_last     (i_last),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_ctrl     (ctrl)
    );

    som_bmu_dp #(
        .MAP_SIZE    (MAP_SIZE),
        .COMPONENTS  (COMPONENTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_status       (status),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_component    (i_component),
        .i_sample_value (i_sample_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_winner_row   (o_winner_row),
        .o_winner_col   (o_winner_col),
        .o_min_distance (o_min_distance)
    );

endmodule

// ===== dv/som_best_matching_unit_l1_test.sv =====
// self-checking testbench for som_best_matching_unit_l1: drives load and query requests,
// predicts each winning neuron with its own l1 map search and checks every result
// depends on som_bmu_pkg and the som_best_matching_unit_l1 rtl

module som_best_matching_unit_l1_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_W           = som_bmu_pkg::ROW_W;
    localparam int COMP_W          = som_bmu_pkg::COMP_W;
    localparam int SAMPLE_W        = som_bmu_pkg::SAMPLE_W;
    localparam int DIST_W          = som_bmu_pkg::DIST_W;
    localparam int VLEN_W          = som_bmu_pkg::VLEN_W;
    localparam int MAP_SIZE        = som_bmu_pkg::MAP_SIZE_DEF;
    localparam int COMPONENTS      = som_bmu_pkg::COMPONENTS_DEF;
    localparam int NEURONS         = MAP_SIZE * MAP_SIZE;
    localparam int SCAN_CYCLES     = NEURONS + $clog2(COMPONENTS) + 4;
    localparam int CLK_PERIOD      = 4;
    localparam int RANDOM_REQUESTS = 1300;
    localparam int RUN_LIMIT_NS    = 40_000_000;
    localparam int DIST_LIMIT      = int'(som_bmu_pkg::DIST_MAX);

    localparam logic CMD_LOAD  = som_bmu_pkg::CMD_LOAD;
    localparam logic CMD_QUERY = som_bmu_pkg::CMD_QUERY;

    localparam logic signed [SAMPLE_W-1:0] VALUE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] VALUE_MIN = 16'sh8000;

    typedef struct packed {
        logic                       cmd;
        logic [ROW_W-1:0]           row;
        logic [ROW_W-1:0]           col;
        logic [COMP_W-1:0]          comp;
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
        logic                       drain_first;
    } t_bmu_request;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [DIST_W-1:0] distance;
    } t_bmu_winner;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_in_valid     = 1'b0;
    logic                       i_cmd          = 1'b0;
    logic [ROW_W-1:0]           i_row          = '0;
    logic [ROW_W-1:0]           i_col          = '0;
    logic [COMP_W-1:0]          i_component    = '0;
    logic signed [SAMPLE_W-1:0] i_sample_value = '0;
    logic                       i_last         = 1'b0;
    logic                       i_cfg_we       = 1'b0;
    logic [VLEN_W-1:0]          i_cfg_data     = '0;
    logic                       i_out_stall    = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [ROW_W-1:0]           o_winner_row;
    logic [ROW_W-1:0]           o_winner_col;
    logic [DIST_W-1:0]          o_min_distance;

    // predictor state
    logic signed [SAMPLE_W-1:0] proto_model [NEURONS*COMPONENTS] = '{default: '0};
    logic signed [SAMPLE_W-1:0] query_model [COMPONENTS]         = '{default: '0};
    logic [VLEN_W-1:0]          model_vlen = som_bmu_pkg::VLEN_RESET;

    // prototypes as they will stand once every queued request has gone in
    logic signed [SAMPLE_W-1:0] proto_shadow [NEURONS*COMPONENTS] = '{default: '0};

    t_bmu_request request_queue[$];
    t_bmu_winner  winner_queue[$];
    t_bmu_request in_flight;
    int           requests_queued = 0;
    int           fault_count     = 0;
    int           send_idle_pct   = 24;
    int           stall_pct       = 60;

    som_best_matching_unit_l1 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_component    (i_component),
        .i_sample_value (i_sample_value),
        .i_last         (i_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_winner_row   (o_winner_row),
        .o_winner_col   (o_winner_col),
        .o_min_distance (o_min_distance)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int effective_len();
        return (int'(model_vlen) > COMPONENTS) ? COMPONENTS : int'(model_vlen);
    endfunction

    // row-major scan, strict less-than so the earliest neuron keeps a tie
    function automatic t_bmu_winner search_winner();
        t_bmu_winner winner;
        int          len;
        int          best;
        int          best_n;
        int          sum;
        int          diff;
        len    = effective_len();
        best   = 0;
        best_n = 0;
        for (int n = 0; n < NEURONS; n++) begin
            sum = 0;
            for (int k = 0; k < len; k++) begin
                diff = int'(query_model[k]) - int'(proto_model[n*COMPONENTS+k]);
                sum += (diff < 0) ? -diff : diff;
                if (sum > DIST_LIMIT) sum = DIST_LIMIT;
            end
            if (n == 0 || sum < best) begin
                best   = sum;
                best_n = n;
            end
        end
        winner.row      = ROW_W'(best_n / MAP_SIZE);
        winner.col      = ROW_W'(best_n % MAP_SIZE);
        winner.distance = DIST_W'(best);
        return winner;
    endfunction

    function automatic void absorb_request(t_bmu_request req);
        if (req.cmd == CMD_LOAD) begin
            if (req.row < MAP_SIZE && req.col < MAP_SIZE && req.comp < COMPONENTS)
                proto_model[(int'(req.row) * MAP_SIZE + int'(req.col)) * COMPONENTS
                            + int'(req.comp)] = req.value;
        end else begin
            if (req.comp < COMPONENTS) query_model[req.comp] = req.value;
            if (req.last) winner_queue.push_back(search_winner());
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            case ($urandom_range(3))
                0: return VALUE_MAX;
                1: return VALUE_MIN;
                2: return '0;
                default: return '1;
            endcase
        end else if (sel < 5) begin
            return SAMPLE_W'(int'($urandom_range(127)) - 64);
        end
        return SAMPLE_W'($urandom());
    endfunction

    function automatic void queue_request(logic cmd, int row, int col, int comp,
                                          logic signed [SAMPLE_W-1:0] value,
                                          logic last, logic drain_first);
        t_bmu_request req;
        req.cmd         = cmd;
        req.row         = ROW_W'(row);
        req.col         = ROW_W'(col);
        req.comp        = COMP_W'(comp);
        req.value       = value;
        req.last        = last;
        req.drain_first = drain_first;
        if (cmd == CMD_LOAD)
            proto_shadow[(row * MAP_SIZE + col) * COMPONENTS + comp] = value;
        request_queue.push_back(req);
        requests_queued++;
    endfunction

    function automatic void load_all_prototypes(bit random_fill,
                                                logic signed [SAMPLE_W-1:0] fill);
        for (int n = 0; n < NEURONS; n++)
            for (int k = 0; k < COMPONENTS; k++)
                queue_request(CMD_LOAD, n / MAP_SIZE, n % MAP_SIZE, k,
                              random_fill ? pick_value() : fill, $urandom_range(1), 1'b0);
    endfunction

    // query close to one neuron's prototype, last set on the final component
    function automatic void queue_query_vector(int neuron, int noise_max, int count,
                                               logic drain_first);
        int noise;
        for (int k = 0; k < count; k++) begin
            noise = int'($urandom_range(2 * noise_max)) - noise_max;
            queue_request(CMD_QUERY, $urandom_range(MAP_SIZE - 1), $urandom_range(MAP_SIZE - 1),
                          k, SAMPLE_W'(int'(proto_shadow[neuron*COMPONENTS+k]) + noise),
                          k == count - 1, drain_first && k == 0);
        end
    endfunction

    function automatic void queue_random_burst();
        int src;
        int dst;
        int pick;
        int count;
        int noise_max;
        // duplicate prototypes set up ties
        if ($urandom_range(9) == 0) begin
            src = $urandom_range(NEURONS - 1);
            dst = $urandom_range(NEURONS - 1);
            for (int k = 0; k < COMPONENTS; k++)
                queue_request(CMD_LOAD, dst / MAP_SIZE, dst % MAP_SIZE, k,
                              proto_shadow[src*COMPONENTS+k], $urandom_range(1), 1'b0);
        end
        repeat ($urandom_range(3))
            queue_request(CMD_LOAD, $urandom_range(MAP_SIZE - 1), $urandom_range(MAP_SIZE - 1),
                          $urandom_range(COMPONENTS - 1), pick_value(), $urandom_range(1), 1'b0);
        pick = $urandom_range(99);
        if (pick < 80) begin
            count = effective_len();
            if (count == 0 || $urandom_range(3) == 0) count = $urandom_range(1, COMPONENTS);
            case ($urandom_range(3))
                0: noise_max = 0;
                1: noise_max = 2;
                2: noise_max = 40;
                default: noise_max = 32768;
            endcase
            queue_query_vector($urandom_range(NEURONS - 1), noise_max, count,
                               $urandom_range(9) == 0);
        end else if (pick < 92) begin
            // components with no closing request
            repeat ($urandom_range(1, 3))
                queue_request(CMD_QUERY, $urandom_range(MAP_SIZE - 1),
                              $urandom_range(MAP_SIZE - 1), $urandom_range(COMPONENTS - 1),
                              pick_value(), 1'b0, 1'b0);
        end else begin
            queue_request(CMD_QUERY, $urandom_range(MAP_SIZE - 1), $urandom_range(MAP_SIZE - 1),
                          $urandom_range(COMPONENTS - 1), pick_value(), 1'b1, 1'b0);
        end
    endfunction

    // wait for every request to go in and every winner to come out, then let a scan pass
    task automatic settle();
        while (request_queue.size() != 0 || i_in_valid || winner_queue.size() != 0)
            @(negedge i_clk);
        repeat (SCAN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_vector_length(logic [VLEN_W-1:0] len);
        settle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_vlen = len;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) absorb_request(in_flight);
            if (!i_in_valid || !o_in_stall) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct
                        && !(request_queue[0].drain_first && winner_queue.size() != 0)) begin
                    in_flight = request_queue.pop_front();
                    i_cmd          <= in_flight.cmd;
                    i_row          <= in_flight.row;
                    i_col          <= in_flight.col;
                    i_component    <= in_flight.comp;
                    i_sample_value <= in_flight.value;
                    i_last         <= in_flight.last;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_bmu_winner expected;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (winner_queue.size() == 0) begin
                $error("unexpected result: row %0d col %0d distance %0d",
                       o_winner_row, o_winner_col, o_min_distance);
                fault_count++;
            end else begin
                expected = winner_queue.pop_front();
                if (o_winner_row !== expected.row) begin
                    $error("winner_row expected %0d got %0d", expected.row, o_winner_row);
                    fault_count++;
                end
                if (o_winner_col !== expected.col) begin
                    $error("winner_col expected %0d got %0d", expected.col, o_winner_col);
                    fault_count++;
                end
                if (o_min_distance !== expected.distance) begin
                    $error("min_distance expected %0d got %0d",
                           expected.distance, o_min_distance);
                    fault_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        int mark;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every prototype at the negative extreme: all neurons tie, first at the largest distance, then at zero
        load_all_prototypes(1'b0, VALUE_MIN);
        for (int k = 0; k < COMPONENTS; k++)
            queue_request(CMD_QUERY, 0, 0, k, VALUE_MAX, k == COMPONENTS - 1, 1'b0);
        for (int k = 0; k < COMPONENTS; k++)
            queue_request(CMD_QUERY, MAP_SIZE - 1, MAP_SIZE - 1, k, VALUE_MIN,
                          k == COMPONENTS - 1, 1'b0);
        load_all_prototypes(1'b1, '0);

        // exact match on the last neuron, then the same vector placed earlier wins the tie
        queue_query_vector(NEURONS - 1, 0, COMPONENTS, 1'b0);
        for (int k = 0; k < COMPONENTS; k++)
            queue_request(CMD_LOAD, 3, 9, k, proto_shadow[(NEURONS-1)*COMPONENTS+k],
                          k == 0, k == 0);
        queue_request(CMD_QUERY, 0, 0, COMPONENTS - 1,
                      proto_shadow[NEURONS*COMPONENTS-1], 1'b1, 1'b0);

        write_vector_length('0);
        queue_request(CMD_QUERY, 5, 5, 0, pick_value(), 1'b1, 1'b0);
        write_vector_length('1);
        queue_query_vector($urandom_range(NEURONS - 1), 0, COMPONENTS, 1'b0);
        write_vector_length(VLEN_W'(1));
        queue_query_vector($urandom_range(NEURONS - 1), 2, 1, 1'b0);

        for (int phase = 0; phase < 3; phase++) begin
            for (int part = 0; part < 4; part++) begin
                write_vector_length(VLEN_W'($urandom_range(15)));
                if (part == 0) begin
                    send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 60 : 0;
                    stall_pct     = (phase == 0) ? 60 : (phase == 1) ? 24 : 0;
                end
                mark = requests_queued;
                while (requests_queued - mark < RANDOM_REQUESTS / 12)
                    queue_random_burst();
            end
        end

        settle();
        if (fault_count == 0 && winner_queue.size() == 0) begin
            $display("PASS som_best_matching_unit_l1");
        end else begin
            $display("FAIL som_best_matching_unit_l1");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL som_best_matching_unit_l1");
        $finish;
    end

endmodule
